### design/lie_pkg.sv
// ----------------------------------------------------------------------------
// lie_pkg
// Types, character codes and control word layout of the line input editor.
// ----------------------------------------------------------------------------
package lie_pkg;

  // buffer limit of the build
  localparam logic [5:0] MAX_LINE = 6'd63;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  // character codes
  localparam logic [7:0] CH_BELL      = 8'h07;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_VDU_ON    = 8'h06;
  localparam logic [7:0] CH_VDU_OFF   = 8'h15;
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_DEL       = 8'h7F;
  localparam logic [7:0] CH_COPY      = 8'h87;
  localparam logic [7:0] CH_CUR_FIRST = 8'h88;
  localparam logic [7:0] CH_CUR_EDIT  = 8'h89;
  localparam logic [7:0] CH_CUR_LAST  = 8'h8B;
  localparam logic [7:0] CH_TOP       = 8'hFF;

  typedef enum logic [1:0] {
    RK_ECHO  = 2'd0,
    RK_STORE = 2'd1,
    RK_DONE  = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    KC_ESC,
    KC_DEL,
    KC_DLINE,
    KC_CURSOR,
    KC_COPY,
    KC_ORD
  } key_class_t;

  typedef enum logic {
    BS_CONST,
    BS_CHR
  } byte_sel_t;

  typedef enum logic {
    PS_ZERO,
    PS_POS
  } pos_sel_t;

  typedef enum logic [1:0] {
    LS_NO,
    LS_YES,
    LS_POS1
  } last_sel_t;

  typedef enum logic [1:0] {
    PO_HOLD,
    PO_DEC,
    PO_CLEAR,
    PO_ADV
  } pos_op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_DISPATCH,
    JC_POS_ZERO,
    JC_CUR_ZERO,
    JC_IS_CR,
    JC_IS_FULL
  } jump_t;

  // one microcode word
  typedef struct packed {
    logic       take;
    logic       emit;
    res_kind_t  kind;
    byte_sel_t  bsel;
    logic [7:0] konst;
    pos_sel_t   psel;
    logic       esc;
    last_sel_t  lsel;
    pos_op_t    pos_op;
    logic       load_copy;
    jump_t      jc;
    pc_t        target;
  } lie_ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    key_class_t cls;
    logic       accept;
    logic       stall;
    logic       pos_zero;
    logic       cur_zero;
    logic       is_cr;
    logic       is_full;
  } lie_stat_t;

endpackage

### design/lie_key_if.sv
// ----------------------------------------------------------------------------
// lie_key_if
// Keypress channel: valid/ready with one keypress per request.
// ----------------------------------------------------------------------------
interface lie_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic       escape_flag;
  logic [7:0] cursor_char;

  modport source (output valid, key_code, escape_flag, cursor_char, input ready);
  modport sink   (input valid, key_code, escape_flag, cursor_char, output ready);
endinterface

### design/lie_res_if.sv
// ----------------------------------------------------------------------------
// lie_res_if
// Result channel: valid/ready with one echo, store or line-done per request.
// ----------------------------------------------------------------------------
interface lie_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic [5:0] position;
  logic       escaped;
  logic       last;

  modport source (output valid, kind, byte_value, position, escaped, last, input ready);
  modport sink   (input valid, kind, byte_value, position, escaped, last, output ready);
endinterface

### design/lie_seq.sv
// ----------------------------------------------------------------------------
// lie_seq
// Step counter and microcode ROM; one control word per step.
// ----------------------------------------------------------------------------
module lie_seq
  import lie_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lie_stat_t stat,
  output lie_ctrl_t cw
);

  localparam pc_t PC_IDLE   = 5'd0;
  localparam pc_t PC_ESC    = 5'd1;
  localparam pc_t PC_DEL    = 5'd2;
  localparam pc_t PC_DLINE  = 5'd4;
  localparam pc_t PC_CURSOR = 5'd6;
  localparam pc_t PC_COPY   = 5'd10;
  localparam pc_t PC_ORD    = 5'd15;
  localparam pc_t PC_BELL   = 5'd18;
  localparam pc_t PC_CR     = 5'd19;

  function automatic lie_ctrl_t nop(jump_t jc, pc_t tgt);
    lie_ctrl_t c;
    c        = '0;
    c.jc     = jc;
    c.target = tgt;
    return c;
  endfunction

  function automatic lie_ctrl_t echo(logic [7:0] b, last_sel_t ls, jump_t jc, pc_t tgt);
    lie_ctrl_t c;
    c       = nop(jc, tgt);
    c.emit  = 1'b1;
    c.kind  = RK_ECHO;
    c.bsel  = BS_CONST;
    c.konst = b;
    c.psel  = PS_ZERO;
    c.lsel  = ls;
    return c;
  endfunction

  function automatic lie_ctrl_t rom(pc_t a);
    lie_ctrl_t c;
    c = nop(JC_ALWAYS, PC_IDLE);
    unique case (a)
      5'd0: begin
        c      = nop(JC_DISPATCH, PC_IDLE);
        c.take = 1'b1;
      end
      // escape: line done, escaped
      5'd1: begin
        c.emit   = 1'b1;
        c.kind   = RK_DONE;
        c.psel   = PS_POS;
        c.esc    = 1'b1;
        c.lsel   = LS_YES;
        c.pos_op = PO_CLEAR;
      end
      // delete
      5'd2: c = nop(JC_POS_ZERO, PC_IDLE);
      5'd3: begin
        c        = echo(CH_DEL, LS_YES, JC_ALWAYS, PC_IDLE);
        c.pos_op = PO_DEC;
      end
      // delete line: loop until empty
      5'd4: c = nop(JC_POS_ZERO, PC_IDLE);
      5'd5: begin
        c        = echo(CH_DEL, LS_POS1, JC_ALWAYS, PC_DLINE);
        c.pos_op = PO_DEC;
      end
      // cursor keys
      5'd6: c = echo(CH_VDU_OFF, LS_NO, JC_NEXT, PC_IDLE);
      5'd7: c = echo(CH_ESC, LS_NO, JC_NEXT, PC_IDLE);
      5'd8: begin
        c      = echo(8'h00, LS_NO, JC_NEXT, PC_IDLE);
        c.bsel = BS_CHR;
      end
      5'd9: c = echo(CH_VDU_ON, LS_YES, JC_ALWAYS, PC_IDLE);
      // copy: fetch cursor char, then fall into ordinary key
      5'd10: begin
        c           = nop(JC_CUR_ZERO, PC_IDLE);
        c.load_copy = 1'b1;
      end
      5'd11: c = echo(CH_VDU_OFF, LS_NO, JC_NEXT, PC_IDLE);
      5'd12: c = echo(CH_ESC, LS_NO, JC_NEXT, PC_IDLE);
      5'd13: c = echo(CH_CUR_EDIT, LS_NO, JC_NEXT, PC_IDLE);
      5'd14: c = echo(CH_VDU_ON, LS_NO, JC_NEXT, PC_IDLE);
      // ordinary key
      5'd15: begin
        c      = nop(JC_IS_CR, PC_CR);
        c.emit = 1'b1;
        c.kind = RK_STORE;
        c.bsel = BS_CHR;
        c.psel = PS_POS;
      end
      5'd16: c = nop(JC_IS_FULL, PC_BELL);
      5'd17: begin
        c        = echo(8'h00, LS_YES, JC_ALWAYS, PC_IDLE);
        c.bsel   = BS_CHR;
        c.pos_op = PO_ADV;
      end
      5'd18: c = echo(CH_BELL, LS_YES, JC_ALWAYS, PC_IDLE);
      // return
      5'd19: c = echo(CH_LF, LS_NO, JC_NEXT, PC_IDLE);
      5'd20: c = echo(CH_CR, LS_NO, JC_NEXT, PC_IDLE);
      5'd21: begin
        c.emit   = 1'b1;
        c.kind   = RK_DONE;
        c.psel   = PS_POS;
        c.lsel   = LS_YES;
        c.pos_op = PO_CLEAR;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic pc_t entry(key_class_t k);
    pc_t p;
    unique case (k)
      KC_ESC:    p = PC_ESC;
      KC_DEL:    p = PC_DEL;
      KC_DLINE:  p = PC_DLINE;
      KC_CURSOR: p = PC_CURSOR;
      KC_COPY:   p = PC_COPY;
      KC_ORD:    p = PC_ORD;
      default:   p = PC_IDLE;
    endcase
    return p;
  endfunction

  pc_t pc, pc_next, pc_inc;

  assign cw     = rom(pc);
  assign pc_inc = pc + 1'b1;

  always_comb begin
    unique case (cw.jc)
      JC_NEXT:     pc_next = pc_inc;
      JC_ALWAYS:   pc_next = cw.target;
      JC_DISPATCH: pc_next = stat.accept   ? entry(stat.cls) : pc;
      JC_POS_ZERO: pc_next = stat.pos_zero ? cw.target : pc_inc;
      JC_CUR_ZERO: pc_next = stat.cur_zero ? cw.target : pc_inc;
      JC_IS_CR:    pc_next = stat.is_cr    ? cw.target : pc_inc;
      JC_IS_FULL:  pc_next = stat.is_full  ? cw.target : pc_inc;
      default:     pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else if (!stat.stall) begin
      pc <= pc_next;
    end
  end

endmodule

### design/lie_dp.sv
// ----------------------------------------------------------------------------
// lie_dp
// Datapath: key latches, write position, flags and the result register.
// ----------------------------------------------------------------------------
module lie_dp
  import lie_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lie_ctrl_t  cw,
  input  logic       key_valid,
  input  logic [7:0] key_code,
  input  logic       escape_flag,
  input  logic [7:0] cursor_char,
  input  logic [5:0] limit,
  input  logic [7:0] min_char,
  input  logic [7:0] max_char,
  input  logic       res_ready,
  output lie_stat_t  stat,
  output logic       res_valid,
  output res_kind_t  res_kind,
  output logic [7:0] res_byte,
  output logic [5:0] res_pos,
  output logic       res_esc,
  output logic       res_last
);

  logic [7:0] chr, cur;
  logic [5:0] pos, pos_next;
  logic       go, in_range, accept;
  key_class_t cls;

  assign accept = cw.take & key_valid;
  assign go     = !(cw.emit & res_valid & !res_ready);

  always_comb begin
    priority if (escape_flag)                  cls = KC_ESC;
    else if (key_code == CH_DEL)               cls = KC_DEL;
    else if (key_code == CH_VDU_OFF)           cls = KC_DLINE;
    else if (key_code >= CH_CUR_FIRST && key_code <= CH_CUR_LAST) cls = KC_CURSOR;
    else if (key_code == CH_COPY)              cls = KC_COPY;
    else                                       cls = KC_ORD;
  end

  assign in_range = (chr >= min_char) && (chr <= max_char);

  assign stat.cls      = cls;
  assign stat.accept   = accept;
  assign stat.stall    = !go;
  assign stat.pos_zero = (pos == 6'd0);
  assign stat.cur_zero = (cur == 8'h00);
  assign stat.is_cr    = (chr == CH_CR);
  assign stat.is_full  = (pos >= limit);

  always_comb begin
    unique case (cw.pos_op)
      PO_HOLD:  pos_next = pos;
      PO_DEC:   pos_next = pos - 1'b1;
      PO_CLEAR: pos_next = 6'd0;
      PO_ADV:   pos_next = in_range ? pos + 1'b1 : pos;
      default:  pos_next = pos;
    endcase
  end

  // key latches
  always_ff @(posedge clk) begin
    if (accept) begin
      chr <= key_code;
      cur <= cursor_char;
    end else if (cw.load_copy) begin
      chr <= (cur == CH_DEL) ? CH_TOP : cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 6'd0;
    end else if (go) begin
      pos <= pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cw.emit && go) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit && go) begin
      res_kind <= cw.kind;
      res_byte <= (cw.bsel == BS_CHR) ? chr : cw.konst;
      res_pos  <= (cw.psel == PS_POS) ? pos : 6'd0;
      res_esc  <= cw.esc;
      unique case (cw.lsel)
        LS_NO:   res_last <= 1'b0;
        LS_YES:  res_last <= 1'b1;
        LS_POS1: res_last <= (pos == 6'd1);
        default: res_last <= 1'b0;
      endcase
    end
  end

endmodule

### design/line_input_editor_top.sv
// ----------------------------------------------------------------------------
// line_input_editor_top
// Console line editor: keypresses in, echo / store / line-done requests out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+----------------------------------------
//  key_ch   | in  | valid / ready  | key_code, escape_flag, cursor_char
//  res_ch   | out | valid / ready  | kind, byte_value, position, escaped, last
//  APB      | in  | psel / penable | max_length @0x0, min_char @0x4,
//           |     |                | max_char @0x8
//
//  Sequencing: a microcode sequencer runs one step per cycle unless it stalls;
//  the idle step takes the keypress and jumps to its routine. Delete does nothing
//  on an empty line, copy does nothing when the cursor char is zero and goes on
//  like return when the copied char is return, and delete-line echoes one delete
//  per stored character.
//  Each emitting step writes the result register; while that register holds
//  an untaken request the step stalls, everything else holds.
//  Reset (rst, synchronous) returns the step counter to idle, clears the
//  write position and loads the register defaults.
//
module line_input_editor_top
  import lie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lie_key_if.sink     key_ch,
  lie_res_if.source   res_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    REG_MAX_LENGTH = 2'd0,
    REG_MIN_CHAR   = 2'd1,
    REG_MAX_CHAR   = 2'd2
  } reg_idx_t;

  logic [5:0] max_length;
  logic [7:0] min_char, max_char;
  logic [5:0] limit;
  logic       wr;
  logic [1:0] idx;

  lie_ctrl_t cw;
  lie_stat_t stat;
  res_kind_t res_kind;

  // ---- configuration registers ----
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= 6'd63;
      min_char   <= 8'd32;
      max_char   <= 8'd255;
    end else if (wr) begin
      // writes beyond the register list are dropped
      unique case (idx)
        REG_MAX_LENGTH: max_length <= pwdata[5:0];
        REG_MIN_CHAR:   min_char   <= pwdata[7:0];
        REG_MAX_CHAR:   max_char   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_LENGTH: prdata = {26'd0, max_length};
      REG_MIN_CHAR:   prdata = {24'd0, min_char};
      REG_MAX_CHAR:   prdata = {24'd0, max_char};
      default:        prdata = 32'd0;
    endcase
  end

  // effective buffer limit: never past the build limit
  assign limit = (max_length < MAX_LINE) ? max_length : MAX_LINE;

  // ---- sequencer ----
  lie_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw)
  );

  // ---- datapath ----
  lie_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cw          (cw),
    .key_valid   (key_ch.valid),
    .key_code    (key_ch.key_code),
    .escape_flag (key_ch.escape_flag),
    .cursor_char (key_ch.cursor_char),
    .limit       (limit),
    .min_char    (min_char),
    .max_char    (max_char),
    .res_ready   (res_ch.ready),
    .stat        (stat),
    .res_valid   (res_ch.valid),
    .res_kind    (res_kind),
    .res_byte    (res_ch.byte_value),
    .res_pos     (res_ch.position),
    .res_esc     (res_ch.escaped),
    .res_last    (res_ch.last)
  );

  // a keypress is taken only in the idle step
  assign key_ch.ready = cw.take;
  assign res_ch.kind  = res_kind;

endmodule

### test/tb_line_input_editor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_input_editor_top
// Self-checking bench for the console line editor. Keypresses go in on the
// key channel and every echo, store and line-done request that comes out is
// checked against an in-bench predictor of the editor. A short scripted run
// covers the special keys and field extremes, then random lines are typed
// under a series of register settings, with bursty stalls on both channels.
// ----------------------------------------------------------------------------
module tb_line_input_editor_top;
  import lie_pkg::*;

  // register map, byte address = 4 * index
  localparam int REG_MAX_LENGTH = 0;
  localparam int REG_MIN_CHAR   = 1;
  localparam int REG_MAX_CHAR   = 2;

  localparam logic [7:0] CUR_NONE = 8'h00;    // cursor char invalid

  localparam int SETTLE_CYCLES = 140;         // covers the worst delete-line
  localparam int HOLD_CYCLES   = 300;         // long receiver hold-off
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int N_SCRIPT      = 23;
  localparam int N_PHASES      = 8;

  // one outgoing request as the editor should produce it
  typedef struct packed {
    res_kind_t  kind;
    logic [7:0] byte_value;
    logic [5:0] position;
    logic       escaped;
    logic       last;
  } editor_event_t;

  // scripted keypress; where typed, the request count and first request
  // are given by hand
  typedef struct {
    logic [7:0] key_code;
    logic       escape_flag;
    logic [7:0] cursor_char;
    bit         typed;
    int         n_events;
    res_kind_t  kind;
    logic [7:0] byte_value;
    logic [5:0] position;
    logic       escaped;
  } script_row_t;

  typedef struct {
    logic [5:0] max_length;
    logic [7:0] min_char;
    logic [7:0] max_char;
    int         n_keys;
    int         end_pct;      // odds of return / escape / delete-line
    bit         hold_off;
    bit         calm;
  } setting_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lie_key_if key_ch ();
  lie_res_if res_ch ();

  line_input_editor_top dut (
    .clk     (clk),
    .rst     (rst),
    .key_ch  (key_ch),
    .res_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // predictor state: editor registers, write position, requests still owed
  // --------------------------------------------------------------------------
  logic [5:0]    ed_max_length;
  logic [7:0]    ed_min_char;
  logic [7:0]    ed_max_char;
  logic [5:0]    wr_pos;
  editor_event_t owed_events[$];

  editor_event_t staged_ev;    // held back so the final one can carry last
  bit            staged_any;
  editor_event_t lead_ev;      // first request of the latest keypress
  int            emitted;

  // bookkeeping
  int  fail_count;
  int  keys_sent;
  int  events_checked;
  int  lines_closed;
  int  bells_rung;
  int  input_stalls;
  int  cycle_count;
  int  hold_asked;
  int  hold_done;
  bit  calm;

  editor_event_t got_ev;
  editor_event_t want_ev;

  // --------------------------------------------------------------------------
  // directed script: special keys, extremes, escape priority
  // --------------------------------------------------------------------------
  script_row_t script [N_SCRIPT] = '{
    // delete on an empty line: nothing
    '{CH_DEL,       1'b0, CUR_NONE, 1, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    // escape on an empty line
    '{8'h41,        1'b1, CUR_NONE, 1, 1, RK_DONE,  8'h00,  6'd0, 1'b1},
    '{8'h41,        1'b0, CUR_NONE, 1, 2, RK_STORE, 8'h41,  6'd0, 1'b0},
    // lowest code, below the range: stored, no advance
    '{8'h00,        1'b0, 8'hFF,    1, 2, RK_STORE, 8'h00,  6'd1, 1'b0},
    '{8'hFF,        1'b0, CUR_NONE, 1, 2, RK_STORE, 8'hFF,  6'd1, 1'b0},
    '{CH_DEL,       1'b0, CUR_NONE, 1, 1, RK_ECHO,  CH_DEL, 6'd0, 1'b0},
    '{CH_CUR_FIRST, 1'b0, 8'hAA,    1, 4, RK_ECHO,  CH_VDU_OFF, 6'd0, 1'b0},
    '{CH_CUR_LAST,  1'b0, 8'h55,    0, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    '{CH_CUR_EDIT,  1'b0, CUR_NONE, 0, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    '{8'h8A,        1'b0, 8'h80,    0, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    // copy with no char under the cursor: nothing
    '{CH_COPY,      1'b0, CUR_NONE, 1, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    // copy of delete becomes the top code
    '{CH_COPY,      1'b0, CH_DEL,   1, 6, RK_ECHO,  CH_VDU_OFF, 6'd0, 1'b0},
    '{CH_COPY,      1'b0, 8'h5A,    0, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    '{8'h1F,        1'b0, CUR_NONE, 0, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    '{8'h20,        1'b0, CUR_NONE, 0, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    '{8'h7E,        1'b0, CUR_NONE, 0, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    '{CH_VDU_OFF,   1'b0, CUR_NONE, 1, 5, RK_ECHO,  CH_DEL, 6'd0, 1'b0},
    // delete-line on an empty line: nothing
    '{CH_VDU_OFF,   1'b0, CUR_NONE, 1, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    '{CH_CR,        1'b0, CUR_NONE, 1, 4, RK_STORE, CH_CR,  6'd0, 1'b0},
    '{8'h42,        1'b0, CUR_NONE, 0, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    // escape beats delete-line
    '{CH_VDU_OFF,   1'b1, 8'hFF,    1, 1, RK_DONE,  8'h00,  6'd1, 1'b1},
    '{8'h80,        1'b0, CUR_NONE, 0, 0, RK_ECHO,  8'h00,  6'd0, 1'b0},
    '{CH_CR,        1'b0, CUR_NONE, 1, 4, RK_STORE, CH_CR,  6'd1, 1'b0}
  };

  // random phases; max_length 3 after a long line leaves the position above
  // the new limit
  setting_t settings [N_PHASES] = '{
    '{6'd0,  8'h00, 8'hFF, 35, 8, 0, 0},    // zero buffer: the bell for every typed char but return
    '{6'd5,  8'h30, 8'h39, 32, 8, 0, 0},    // digits only
    '{6'd63, 8'h00, 8'hFF, 60, 1, 1, 0},    // long lines, receiver hold-off
    '{6'd3,  8'h20, 8'h7E, 35, 8, 0, 0},
    '{6'd63, 8'hC8, 8'h64, 30, 8, 0, 0},    // empty range
    '{6'd1,  8'hFF, 8'hFF, 30, 8, 0, 0},
    '{6'd40, 8'h00, 8'h00, 25, 8, 0, 0},
    '{6'd63, 8'h20, 8'hFF, 40, 6, 0, 1}     // reset values, no idling
  };

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic void stage_event(res_kind_t k, logic [7:0] b, logic [5:0] p,
                                      logic e);
    if (staged_any)
      owed_events.push_back(staged_ev);
    staged_ev  = '{k, b, p, e, 1'b0};
    staged_any = 1'b1;
    if (emitted == 0)
      lead_ev = staged_ev;
    emitted++;
  endfunction

  function automatic void close_line(logic esc);
    stage_event(RK_DONE, 8'h00, wr_pos, esc);
    wr_pos = '0;
    lines_closed++;
  endfunction

  // works out every request one keypress owes; returns their number
  function automatic int apply_keypress(logic [7:0] kc, logic ef, logic [7:0] cc);
    logic [7:0] ch;
    logic [5:0] lim;
    bit         plain;
    emitted    = 0;
    staged_any = 1'b0;
    lim   = (ed_max_length < MAX_LINE) ? ed_max_length : MAX_LINE;
    ch    = kc;
    plain = 1'b1;
    if (ef) begin
      close_line(1'b1);
    end else if (kc == CH_DEL) begin
      if (wr_pos != 0) begin
        stage_event(RK_ECHO, CH_DEL, 6'd0, 1'b0);
        wr_pos--;
      end
    end else if (kc == CH_VDU_OFF) begin
      while (wr_pos != 0) begin
        stage_event(RK_ECHO, CH_DEL, 6'd0, 1'b0);
        wr_pos--;
      end
    end else if (kc >= CH_CUR_FIRST && kc <= CH_CUR_LAST) begin
      stage_event(RK_ECHO, CH_VDU_OFF, 6'd0, 1'b0);
      stage_event(RK_ECHO, CH_ESC, 6'd0, 1'b0);
      stage_event(RK_ECHO, kc, 6'd0, 1'b0);
      stage_event(RK_ECHO, CH_VDU_ON, 6'd0, 1'b0);
    end else begin
      if (kc == CH_COPY) begin
        ch = cc;
        if (cc == CUR_NONE) begin
          plain = 1'b0;
        end else begin
          if (ch == CH_DEL)
            ch = CH_TOP;
          stage_event(RK_ECHO, CH_VDU_OFF, 6'd0, 1'b0);
          stage_event(RK_ECHO, CH_ESC, 6'd0, 1'b0);
          stage_event(RK_ECHO, CH_CUR_EDIT, 6'd0, 1'b0);
          stage_event(RK_ECHO, CH_VDU_ON, 6'd0, 1'b0);
        end
      end
      if (plain) begin
        stage_event(RK_STORE, ch, wr_pos, 1'b0);
        if (ch == CH_CR) begin
          stage_event(RK_ECHO, CH_LF, 6'd0, 1'b0);
          stage_event(RK_ECHO, CH_CR, 6'd0, 1'b0);
          close_line(1'b0);
        end else if (wr_pos >= lim) begin
          stage_event(RK_ECHO, CH_BELL, 6'd0, 1'b0);
          bells_rung++;
        end else begin
          stage_event(RK_ECHO, ch, 6'd0, 1'b0);
          if (ch >= ed_min_char && ch <= ed_max_char)
            wr_pos++;
        end
      end
    end
    if (staged_any) begin
      staged_ev.last = 1'b1;
      owed_events.push_back(staged_ev);
    end
    return emitted;
  endfunction

  // --------------------------------------------------------------------------
  // clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d requests still owed", $time, owed_events.size());
      $display("line_input_editor_top verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // result checker: every request taken is matched against the oldest owed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got_ev = '{res_kind_t'(res_ch.kind), res_ch.byte_value, res_ch.position,
                 res_ch.escaped, res_ch.last};
      events_checked++;
      if (owed_events.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected request kind=%0d byte=%02h pos=%0d esc=%b last=%b",
                 $time, got_ev.kind, got_ev.byte_value, got_ev.position,
                 got_ev.escaped, got_ev.last);
      end else begin
        want_ev = owed_events.pop_front();
        if (got_ev !== want_ev) begin
          fail_count++;
          $display("%0t: mismatch, expected kind=%0d byte=%02h pos=%0d esc=%b last=%b",
                   $time, want_ev.kind, want_ev.byte_value, want_ev.position,
                   want_ev.escaped, want_ev.last);
          $display("%0t:           actual kind=%0d byte=%02h pos=%0d esc=%b last=%b",
                   $time, got_ev.kind, got_ev.byte_value, got_ev.position,
                   got_ev.escaped, got_ev.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: ready in random bursts, one long hold-off on request, always
  // ready in the calm tail
  // --------------------------------------------------------------------------
  initial begin
    int span;
    bit stall;
    res_ch.ready = 1'b0;
    forever begin
      if (hold_asked != hold_done) begin
        @(negedge clk) res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = hold_asked;
      end else if (calm) begin
        @(negedge clk) res_ch.ready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 2) == 0);
        span  = stall ? $urandom_range(1, 18) : $urandom_range(1, 40);
        @(negedge clk) res_ch.ready <= !stall;
        repeat (span - 1) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // one keypress request; predicted once the editor takes it
  task automatic offer_keypress(input logic [7:0] kc, input logic ef,
                                input logic [7:0] cc, output int n_events);
    @(negedge clk);
    key_ch.valid       <= 1'b1;
    key_ch.key_code    <= kc;
    key_ch.escape_flag <= ef;
    key_ch.cursor_char <= cc;
    do begin
      @(posedge clk);
      if (!key_ch.ready)
        input_stalls++;
    end while (!key_ch.ready);
    n_events = apply_keypress(kc, ef, cc);
    keys_sent++;
  endtask

  // random idle burst between requests
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk) key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
  endtask

  // mostly printable text; line ends at end_pct percent, then the edit keys
  task automatic pick_keypress(input int end_pct, output logic [7:0] kc,
                               output logic ef, output logic [7:0] cc);
    int roll;
    roll = $urandom_range(0, 99);
    kc   = 8'($urandom_range(32, 126));
    ef   = 1'b0;
    cc   = 8'($urandom_range(0, 255));
    if (roll < end_pct) begin
      case ($urandom_range(0, 2))
        0:       kc = CH_CR;
        1: begin
          ef = 1'b1;
          kc = 8'($urandom_range(0, 255));
        end
        default: kc = CH_VDU_OFF;
      endcase
    end else if (roll < end_pct + 6) begin
      kc = CH_DEL;
    end else if (roll < end_pct + 10) begin
      kc = 8'($urandom_range(0, 255));
    end else if (roll < end_pct + 14) begin
      kc = 8'($urandom_range(CH_CUR_FIRST, CH_CUR_LAST));
    end else if (roll < end_pct + 20) begin
      kc = CH_COPY;
      case ($urandom_range(0, 3))
        0:       cc = CUR_NONE;
        1:       cc = CH_DEL;
        default: ;
      endcase
    end
  endtask

  // wait until every owed request is out, then let the sequencer settle
  task automatic drain();
    @(negedge clk) key_ch.valid <= 1'b0;
    while (owed_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic [3:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a register, mirror it in the predictor, read it back
  task automatic set_register(input int idx, input logic [7:0] val);
    logic [31:0] rd;
    logic [31:0] mask;
    apb_access(1'b1, 4'(idx * 4), 32'(val), rd);
    case (idx)
      REG_MAX_LENGTH: begin
        ed_max_length = val[5:0];
        mask = 32'h3F;
      end
      REG_MIN_CHAR: begin
        ed_min_char = val;
        mask = 32'hFF;
      end
      default: begin
        ed_max_char = val;
        mask = 32'hFF;
      end
    endcase
    apb_access(1'b0, 4'(idx * 4), 32'h0, rd);
    if ((rd & mask) !== (32'(val) & mask)) begin
      fail_count++;
      $display("%0t: register %0d read back, expected %02h actual %02h",
               $time, idx, 32'(val) & mask, rd & mask);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] kc;
    logic       ef;
    logic [7:0] cc;
    int         n;

    // everything known from time zero
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    key_ch.valid       = 1'b0;
    key_ch.key_code    = '0;
    key_ch.escape_flag = 1'b0;
    key_ch.cursor_char = '0;
    fail_count     = 0;
    keys_sent      = 0;
    events_checked = 0;
    lines_closed   = 0;
    bells_rung     = 0;
    input_stalls   = 0;
    cycle_count    = 0;
    hold_asked     = 0;
    hold_done      = 0;
    calm           = 1'b0;
    emitted        = 0;
    staged_any     = 1'b0;

    // predictor at its reset values
    ed_max_length = 6'd63;
    ed_min_char   = 8'h20;
    ed_max_char   = 8'hFF;
    wr_pos        = '0;

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // scripted keys under the reset register values
    for (int i = 0; i < N_SCRIPT; i++) begin
      offer_keypress(script[i].key_code, script[i].escape_flag,
                     script[i].cursor_char, n);
      if (script[i].typed &&
          (n != script[i].n_events ||
           (n > 0 && (lead_ev.kind != script[i].kind ||
                      lead_ev.byte_value != script[i].byte_value ||
                      lead_ev.position != script[i].position ||
                      lead_ev.escaped != script[i].escaped)))) begin
        fail_count++;
        $display("%0t: script row %0d, expected %0d requests led by %0d/%02h/%0d/%b",
                 $time, i, script[i].n_events, script[i].kind,
                 script[i].byte_value, script[i].position, script[i].escaped);
        $display("%0t: script row %0d,   actual %0d requests led by %0d/%02h/%0d/%b",
                 $time, i, n, lead_ev.kind, lead_ev.byte_value, lead_ev.position,
                 lead_ev.escaped);
      end
      sender_gap();
    end
    drain();

    // random typing, one register setting per phase; the position carries
    // over from phase to phase
    for (int p = 0; p < N_PHASES; p++) begin
      set_register(REG_MAX_LENGTH, 8'(settings[p].max_length));
      set_register(REG_MIN_CHAR, settings[p].min_char);
      set_register(REG_MAX_CHAR, settings[p].max_char);
      calm = settings[p].calm;
      if (settings[p].hold_off)
        hold_asked++;
      for (int k = 0; k < settings[p].n_keys; k++) begin
        pick_keypress(settings[p].end_pct, kc, ef, cc);
        offer_keypress(kc, ef, cc, n);
        sender_gap();
      end
      drain();
    end

    $display("Run covered %0d keypresses (%0d scripted) across %0d register settings.",
             keys_sent, N_SCRIPT, N_PHASES + 1);
    $display("%0d requests checked: %0d lines finished, %0d bells, %0d input stall cycles.",
             events_checked, lines_closed, bells_rung, input_stalls);
    if (fail_count == 0 && owed_events.size() == 0)
      $display("line_input_editor_top verification clean");
    else
      $display("line_input_editor_top verification failed");
    $finish;
  end

endmodule

### line_input_editor_top.f
design/lie_pkg.sv
design/lie_key_if.sv
design/lie_res_if.sv
design/lie_seq.sv
design/lie_dp.sv
design/line_input_editor_top.sv
test/tb_line_input_editor_top.sv
